/* rtl/qr_version_info_decoder_macros.svh */
// ----------------------------------------------------------------------------
// QR version information decoder assertion macros
// Concurrent check wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QR_VERSION_INFO_DECODER_MACROS_SVH
`define QR_VERSION_INFO_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent.
`define QRVID_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an expression never holds.
`define QRVID_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`else

`define QRVID_ASSERT_IMPL(label, ante, cons, msg)
`define QRVID_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* rtl/qrvid_pkg.sv */
// ----------------------------------------------------------------------------
// QR version information decoder package
// Codeword table, field widths, distance types and helper functions.
// ----------------------------------------------------------------------------
package qrvid_pkg;

	localparam int WORD_BITS     = 18;
	localparam int DIST_BITS     = 5;
	localparam int VER_BITS      = 6;
	localparam int NUM_CODES     = 34;
	localparam int FIRST_VERSION = 7;

	localparam logic [DIST_BITS-1:0] TOL_RESET = 5'd3;

	// BCH(18,6) version codewords, versions 7 to 40
	localparam logic [WORD_BITS-1:0] CODE_TABLE [NUM_CODES] = '{
		18'h07C94, 18'h085BC, 18'h09A99, 18'h0A4D3, 18'h0BBF6,
		18'h0C762, 18'h0D847, 18'h0E60D, 18'h0F928, 18'h10B78,
		18'h1145D, 18'h12A17, 18'h13532, 18'h149A6, 18'h15683,
		18'h168C9, 18'h177EC, 18'h18EC4, 18'h191E1, 18'h1AFAB,
		18'h1B08E, 18'h1CC1A, 18'h1D33F, 18'h1ED75, 18'h1F250,
		18'h209D5, 18'h216F0, 18'h228BA, 18'h2379F, 18'h24B0B,
		18'h2542E, 18'h26A64, 18'h27541, 18'h28C69
	};

	typedef struct packed {
		logic [DIST_BITS-1:0] hdist;
		logic [VER_BITS-1:0]  ver;
	} dv_t;

	// Count set bits: six 3-bit groups, then sum the groups
	function automatic logic [DIST_BITS-1:0] ones18(input logic [WORD_BITS-1:0] w);
		logic [1:0]           grp;
		logic [DIST_BITS-1:0] n;
		n = '0;
		for (int g = 0; g < WORD_BITS / 3; g++) begin
			grp = 2'(w[3*g]) + 2'(w[3*g+1]) + 2'(w[3*g+2]);
			n = n + DIST_BITS'(grp);
		end
		return n;
	endfunction

	// Left side holds the lower version; the right side wins only if strictly closer
	function automatic dv_t pick(input dv_t lo, input dv_t hi);
		return (hi.hdist < lo.hdist) ? hi : lo;
	endfunction

endpackage

/* rtl/qr_version_info_decoder.sv */
// ----------------------------------------------------------------------------
// QR version information decoder
// Matches two 18-bit version words against the 34 BCH(18,6) codewords and
// reports the closest version when within the bit error tolerance.
// ----------------------------------------------------------------------------
//
//   channel   valid          stall          payload
//   -------   ------------   ------------   --------------------------
//   item      item_valid     item_stall     bits_a, bits_b
//   result    result_valid   result_stall   found, version, distance
//   config    cfg_we         (none)         cfg_wdata -> max_bit_errors
//
// One word enters every cycle while item_stall is low; results leave stage 3.
// Stage 1 finds the distance per version, stage 2 reduces 34 to 5
// candidates, stage 3 picks the best and applies the tolerance.
// Reset clears the valid bits and loads a tolerance of 3.
// A stall holds full stages with no bubble ahead; the others still advance.
//
`include "qr_version_info_decoder_macros.svh"

module qr_version_info_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [qrvid_pkg::WORD_BITS-1:0] bits_a,
	input  logic [qrvid_pkg::WORD_BITS-1:0] bits_b,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            found,
	output logic [qrvid_pkg::VER_BITS-1:0]  version,
	output logic [qrvid_pkg::DIST_BITS-1:0] distance,
	input  logic                            cfg_we,
	input  logic [qrvid_pkg::DIST_BITS-1:0] cfg_wdata
);

	localparam int N1 = 17;
	localparam int N2 = 9;
	localparam int N3 = 5;

	logic [qrvid_pkg::DIST_BITS-1:0] max_bit_errors_q;

	logic valid_s1, valid_s2, valid_s3;
	logic move1, move2, move3;

	qrvid_pkg::dv_t dv_d  [qrvid_pkg::NUM_CODES];
	qrvid_pkg::dv_t dv_s1 [qrvid_pkg::NUM_CODES];
	qrvid_pkg::dv_t l1    [N1];
	qrvid_pkg::dv_t l2    [N2];
	qrvid_pkg::dv_t l3    [N3];
	qrvid_pkg::dv_t cand_s2 [N3];
	qrvid_pkg::dv_t l4    [3];
	qrvid_pkg::dv_t l5    [2];
	qrvid_pkg::dv_t best;

	logic                            found_s3;
	logic [qrvid_pkg::VER_BITS-1:0]  version_s3;
	logic [qrvid_pkg::DIST_BITS-1:0] distance_s3;

	// a stage advances when empty or when the next one advances
	assign move3      = !valid_s3 || !result_stall;
	assign move2      = !valid_s2 || move3;
	assign move1      = !valid_s1 || move2;
	assign item_stall = !move1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bit_errors_q <= qrvid_pkg::TOL_RESET;
		end else if (cfg_we) begin
			max_bit_errors_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (move1) valid_s1 <= item_valid;
			if (move2) valid_s2 <= valid_s1;
			if (move3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: distance of each version, closer copy of the two
	always_comb begin
		logic [qrvid_pkg::DIST_BITS-1:0] da;
		logic [qrvid_pkg::DIST_BITS-1:0] db;
		for (int i = 0; i < qrvid_pkg::NUM_CODES; i++) begin
			da = qrvid_pkg::ones18(bits_a ^ qrvid_pkg::CODE_TABLE[i]);
			db = qrvid_pkg::ones18(bits_b ^ qrvid_pkg::CODE_TABLE[i]);
			// copy A wins a tie
			dv_d[i].hdist = (db < da) ? db : da;
			dv_d[i].ver   = qrvid_pkg::VER_BITS'(qrvid_pkg::FIRST_VERSION + i);
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			for (int i = 0; i < qrvid_pkg::NUM_CODES; i++) begin
				dv_s1[i] <= dv_d[i];
			end
		end
	end

	// Stage 2: three tree levels, 34 -> 17 -> 9 -> 5
	always_comb begin
		for (int i = 0; i < N1; i++) begin
			l1[i] = qrvid_pkg::pick(dv_s1[2*i], dv_s1[2*i+1]);
		end
		for (int i = 0; i < N2 - 1; i++) begin
			l2[i] = qrvid_pkg::pick(l1[2*i], l1[2*i+1]);
		end
		l2[N2-1] = l1[N1-1];
		for (int i = 0; i < N3 - 1; i++) begin
			l3[i] = qrvid_pkg::pick(l2[2*i], l2[2*i+1]);
		end
		l3[N3-1] = l2[N2-1];
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			for (int i = 0; i < N3; i++) begin
				cand_s2[i] <= l3[i];
			end
		end
	end

	// Stage 3: 5 -> 3 -> 2 -> 1, then the tolerance check
	always_comb begin
		l4[0] = qrvid_pkg::pick(cand_s2[0], cand_s2[1]);
		l4[1] = qrvid_pkg::pick(cand_s2[2], cand_s2[3]);
		l4[2] = cand_s2[4];
		l5[0] = qrvid_pkg::pick(l4[0], l4[1]);
		l5[1] = l4[2];
		best  = qrvid_pkg::pick(l5[0], l5[1]);
	end

	always_ff @(posedge clk) begin
		if (move3) begin
			found_s3    <= (best.hdist <= max_bit_errors_q);
			version_s3  <= (best.hdist <= max_bit_errors_q) ? best.ver : '0;
			distance_s3 <= best.hdist;
		end
	end

	assign result_valid = valid_s3;
	assign found        = found_s3;
	assign version      = version_s3;
	assign distance     = distance_s3;

	`QRVID_ASSERT_IMPL(a_found_within_tol, result_valid && found, distance <= max_bit_errors_q, "found with distance above tolerance")
	`QRVID_ASSERT_IMPL(a_miss_no_version, result_valid && !found, version == '0 && distance > max_bit_errors_q, "miss reports a version or a distance within tolerance")
	`QRVID_ASSERT_IMPL(a_version_range, result_valid && found, version >= 6'd7 && version <= 6'd40, "version out of range")
	`QRVID_ASSERT_NEVER(a_stall_only_full, item_stall && !(valid_s1 && valid_s2 && valid_s3), "input stalled with a bubble in the pipe")

endmodule
